### rtl/mtep_pkg.sv
// shared types and constants for the midi track event parser
// no dependencies; compiled first

package mtep_pkg;

  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam int unsigned LEN_W  = 28;
  localparam int unsigned SEEN_W = 3;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned TEMPO_W = 24;

  localparam logic [7:0] DATA_MASK     = 8'h7F;
  localparam logic [7:0] STATUS_MIN    = 8'h80;
  localparam logic [7:0] CHAN_MAX      = 8'hEF;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE  = 8'hF7;
  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_EOT      = 8'h2F;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [LEN_W-1:0] TEMPO_LEN = LEN_W'(3);

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_EOT     = 2'd2,
    KIND_ERROR   = 2'd3
  } mtep_kind_t;

  typedef struct packed {
    mtep_kind_t          kind;
    logic [TICK_W-1:0]   abs_tick;
    logic [3:0]          event_type;
    logic [3:0]          channel;
    logic [7:0]          first_data;
    logic [7:0]          second_data;
    logic [TEMPO_W-1:0]  tempo_us;
  } mtep_result_t;

endpackage

### rtl/mtep_in_if.sv
// byte channel into the parser: valid/ready handshake with one track byte
// depends on nothing

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_track;

  modport source (output valid, output data_byte, output new_track, input ready);
  modport sink   (input valid, input data_byte, input new_track, output ready);
endinterface

### rtl/mtep_out_if.sv
// event channel out of the parser: valid/ready handshake with one event
// depends on mtep_pkg for the kind type

interface mtep_out_if;
  logic                valid;
  logic                ready;
  mtep_pkg::mtep_kind_t kind;
  logic [31:0]         abs_tick;
  logic [3:0]          event_type;
  logic [3:0]          channel;
  logic [7:0]          first_data;
  logic [7:0]          second_data;
  logic [23:0]         tempo_us;

  modport source (output valid, output kind, output abs_tick, output event_type,
                  output channel, output first_data, output second_data,
                  output tempo_us, input ready);
  modport sink   (input valid, input kind, input abs_tick, input event_type,
                  input channel, input first_data, input second_data,
                  input tempo_us, output ready);
endinterface

### rtl/mtep_core.sv
// parser state and single-byte step logic: delta, status, data, meta, sysex
// depends on mtep_pkg

module mtep_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic                  new_track,
  output logic                  emit,
  output mtep_pkg::mtep_result_t res
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_LEN       = 4'd5,
    PH_SKIP      = 4'd6,
    PH_TEMPO     = 4'd7,
    PH_DONE      = 4'd8
  } phase_t;

  phase_t              phase, phase_next, phase_eff;
  logic [LEN_W-1:0]    length_accum, length_accum_next, acc_eff;
  logic [SEEN_W-1:0]   length_bytes_seen, length_bytes_seen_next, seen_eff;
  logic [7:0]          running_status, running_status_next, rs_eff;
  logic [7:0]          current_status, current_status_next, cs_eff;
  logic [7:0]          held_data, held_data_next, held_eff;
  logic [7:0]          meta_kind, meta_kind_next, mk_eff;
  logic [LEN_W-1:0]    bytes_to_skip, bytes_to_skip_next, skip_eff;
  logic [TEMPO_W-1:0]  tempo_accum, tempo_accum_next, tempo_eff;
  logic [TICK_W-1:0]   tick_count, tick_count_next, tick_eff;

  logic [LEN_W-1:0]    acc_base, acc_upd, skip_dec;
  logic [SEEN_W-1:0]   seen_base, seen_upd;
  logic                len_done, len_over;
  logic [7:0]          cs_sel;

  // new_track applies the cleared state before the byte is taken
  always_comb begin
    if (new_track) begin
      phase_eff = PH_DELTA;
      acc_eff   = '0;
      seen_eff  = '0;
      rs_eff    = '0;
      cs_eff    = '0;
      held_eff  = '0;
      mk_eff    = '0;
      skip_eff  = '0;
      tempo_eff = '0;
      tick_eff  = '0;
    end else begin
      phase_eff = phase;
      acc_eff   = length_accum;
      seen_eff  = length_bytes_seen;
      rs_eff    = running_status;
      cs_eff    = current_status;
      held_eff  = held_data;
      mk_eff    = meta_kind;
      skip_eff  = bytes_to_skip;
      tempo_eff = tempo_accum;
      tick_eff  = tick_count;
    end
  end

  // variable-length quantity byte
  always_comb begin
    if (phase_eff == PH_LEN || phase_eff == PH_DELTA) begin
      acc_base  = acc_eff;
      seen_base = seen_eff;
    end else begin
      acc_base  = '0;
      seen_base = '0;
    end
    acc_upd  = {acc_base[LEN_W-8:0], data_byte[6:0]};
    seen_upd = seen_base + SEEN_W'(1);
    len_done = !data_byte[7];
    len_over = data_byte[7] && (seen_upd >= SEEN_W'(MAX_LENGTH_BYTES));
    skip_dec = skip_eff - LEN_W'(1);
  end

  always_comb begin
    phase_next             = phase_eff;
    length_accum_next      = acc_eff;
    length_bytes_seen_next = seen_eff;
    running_status_next    = rs_eff;
    current_status_next    = cs_eff;
    held_data_next         = held_eff;
    meta_kind_next         = mk_eff;
    bytes_to_skip_next     = skip_eff;
    tempo_accum_next       = tempo_eff;
    tick_count_next        = tick_eff;
    emit                   = 1'b0;
    cs_sel                 = cs_eff;
    res                    = '0;
    res.abs_tick           = tick_eff;

    case (phase_eff)
      PH_STATUS: begin
        if (data_byte < STATUS_MIN) begin
          if (rs_eff == '0) begin
            phase_next = PH_DONE;
            emit       = 1'b1;
            res.kind   = KIND_ERROR;
          end else begin
            cs_sel              = rs_eff;
            current_status_next = rs_eff;
            if (cs_sel[7:4] == TYPE_PROGRAM || cs_sel[7:4] == TYPE_PRESSURE) begin
              phase_next             = PH_DELTA;
              length_accum_next      = '0;
              length_bytes_seen_next = '0;
              emit                   = 1'b1;
              res.kind               = KIND_CHANNEL;
              res.event_type         = cs_sel[7:4];
              res.channel            = cs_sel[3:0];
              res.first_data         = data_byte;
            end else begin
              held_data_next = data_byte;
              phase_next     = PH_DATA2;
            end
          end
        end else begin
          current_status_next = data_byte;
          if (data_byte <= CHAN_MAX) begin
            running_status_next = data_byte;
            phase_next          = PH_DATA1;
          end else begin
            running_status_next = '0;
            if (data_byte == META_STATUS) begin
              phase_next = PH_META_TYPE;
            end else begin
              length_accum_next      = '0;
              length_bytes_seen_next = '0;
              if (data_byte == SYSEX_START || data_byte == SYSEX_ESCAPE) begin
                phase_next = PH_LEN;
              end else begin
                phase_next = PH_DELTA;
              end
            end
          end
        end
      end
      PH_DATA1: begin
        if (cs_eff[7:4] == TYPE_PROGRAM || cs_eff[7:4] == TYPE_PRESSURE) begin
          phase_next             = PH_DELTA;
          length_accum_next      = '0;
          length_bytes_seen_next = '0;
          emit                   = 1'b1;
          res.kind               = KIND_CHANNEL;
          res.event_type         = cs_eff[7:4];
          res.channel            = cs_eff[3:0];
          res.first_data         = data_byte;
        end else begin
          held_data_next = data_byte;
          phase_next     = PH_DATA2;
        end
      end
      PH_DATA2: begin
        phase_next             = PH_DELTA;
        length_accum_next      = '0;
        length_bytes_seen_next = '0;
        emit                   = 1'b1;
        res.kind               = KIND_CHANNEL;
        res.event_type         = cs_eff[7:4];
        res.channel            = cs_eff[3:0];
        res.first_data         = held_eff;
        res.second_data        = data_byte;
      end
      PH_META_TYPE: begin
        meta_kind_next         = data_byte;
        phase_next             = PH_LEN;
        length_accum_next      = '0;
        length_bytes_seen_next = '0;
      end
      PH_LEN: begin
        length_accum_next      = acc_upd;
        length_bytes_seen_next = seen_upd;
        if (len_done) begin
          if (cs_eff == META_STATUS && mk_eff == META_EOT) begin
            phase_next = PH_DONE;
            emit       = 1'b1;
            res.kind   = KIND_EOT;
          end else if (cs_eff == META_STATUS && mk_eff == META_TEMPO &&
                       acc_upd == TEMPO_LEN) begin
            bytes_to_skip_next = TEMPO_LEN;
            tempo_accum_next   = '0;
            phase_next         = PH_TEMPO;
          end else if (acc_upd == '0) begin
            phase_next             = PH_DELTA;
            length_accum_next      = '0;
            length_bytes_seen_next = '0;
          end else begin
            bytes_to_skip_next = acc_upd;
            phase_next         = PH_SKIP;
          end
        end else if (len_over) begin
          phase_next = PH_DONE;
          emit       = 1'b1;
          res.kind   = KIND_ERROR;
        end
      end
      PH_SKIP: begin
        bytes_to_skip_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next             = PH_DELTA;
          length_accum_next      = '0;
          length_bytes_seen_next = '0;
        end
      end
      PH_TEMPO: begin
        tempo_accum_next   = {tempo_eff[TEMPO_W-9:0], data_byte};
        bytes_to_skip_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next             = PH_DELTA;
          length_accum_next      = '0;
          length_bytes_seen_next = '0;
          emit                   = 1'b1;
          res.kind               = KIND_TEMPO;
          res.tempo_us           = {tempo_eff[TEMPO_W-9:0], data_byte};
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        // delta time, and any unused phase code
        phase_next             = PH_DELTA;
        length_accum_next      = acc_upd;
        length_bytes_seen_next = seen_upd;
        if (len_done) begin
          tick_count_next = tick_eff + TICK_W'(acc_upd);
          phase_next      = PH_STATUS;
        end else if (len_over) begin
          phase_next = PH_DONE;
          emit       = 1'b1;
          res.kind   = KIND_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_DELTA;
      length_accum      <= '0;
      length_bytes_seen <= '0;
      running_status    <= '0;
      current_status    <= '0;
      held_data         <= '0;
      meta_kind         <= '0;
      bytes_to_skip     <= '0;
      tempo_accum       <= '0;
      tick_count        <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      length_accum      <= length_accum_next;
      length_bytes_seen <= length_bytes_seen_next;
      running_status    <= running_status_next;
      current_status    <= current_status_next;
      held_data         <= held_data_next;
      meta_kind         <= meta_kind_next;
      bytes_to_skip     <= bytes_to_skip_next;
      tempo_accum       <= tempo_accum_next;
      tick_count        <= tick_count_next;
    end
  end

endmodule

### rtl/midi_track_event_parser.sv
// top level: input byte register, parser core, event output register
// depends on mtep_pkg, mtep_in_if, mtep_out_if, mtep_core
//
//   channel  dir  beat                                     width
//   track    in   data_byte, new_track                     9
//   result   out  kind, abs_tick, event_type, channel,     82
//                 first_data, second_data, tempo_us
//
// one byte per cycle while result.ready is high, via the byte and result registers.
// the byte register feeds the core, which updates state and loads the result register
// in the same cycle; the result register holds while result.ready is low, and the
// byte register then holds one more byte before track.ready drops.
// rst is synchronous and clears both valid flags and all parser state.

module midi_track_event_parser (
  input logic        clk,
  input logic        rst,
  mtep_in_if.sink    track,
  mtep_out_if.source result
);
  import mtep_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_new_q;
  logic         res_valid_q;
  mtep_result_t res_q;
  mtep_result_t core_res;
  logic         core_emit;
  logic         fire;

  assign fire        = in_valid_q && (!res_valid_q || result.ready);
  assign track.ready = !in_valid_q || fire;

  mtep_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte_q),
    .new_track (in_new_q),
    .emit      (core_emit),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (track.valid && track.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (track.valid && track.ready) begin
      in_byte_q <= track.data_byte;
      in_new_q  <= track.new_track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (fire && core_emit) begin
      res_valid_q <= 1'b1;
    end else if (result.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && core_emit) begin
      res_q <= core_res;
    end
  end

  assign result.valid       = res_valid_q;
  assign result.kind        = res_q.kind;
  assign result.abs_tick    = res_q.abs_tick;
  assign result.event_type  = res_q.event_type;
  assign result.channel     = res_q.channel;
  assign result.first_data  = res_q.first_data;
  assign result.second_data = res_q.second_data;
  assign result.tempo_us    = res_q.tempo_us;

endmodule

### tb/sv/midi_track_event_parser_test.sv
// testbench for midi_track_event_parser: directed and random track bytes with
// random idling on both sides, events predicted per byte and checked in order
// depends on mtep_pkg, mtep_in_if, mtep_out_if and the parser rtl

module midi_track_event_parser_test;
  import mtep_pkg::*;

  localparam int unsigned ITEMS = 1950;

  typedef enum logic [3:0] {
    P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_META_TYPE, P_LEN, P_SKIP, P_TEMPO, P_DONE
  } parse_phase_t;

  typedef enum logic [1:0] {LS_MORE, LS_END, LS_OVER} len_step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } track_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic hold;

  mtep_in_if  track_if ();
  mtep_out_if event_if ();

  midi_track_event_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .track  (track_if),
    .result (event_if)
  );

  always #10 clk = ~clk;

  track_beat_t  pending[$];
  mtep_result_t events_due[$];
  int unsigned  errors = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  sent = 0;
  int unsigned  beats_seen = 0;
  int unsigned  gap_left;
  int unsigned  stall_left;

  // parser state
  parse_phase_t        ph;
  logic [LEN_W-1:0]    len_acc;
  logic [SEEN_W-1:0]   len_seen;
  logic [7:0]          run_st;
  logic [7:0]          cur_st;
  logic [7:0]          held;
  logic [7:0]          meta_type;
  logic [LEN_W-1:0]    skip_left;
  logic [TEMPO_W-1:0]  tempo_acc;
  logic [TICK_W-1:0]   tick;
  logic                trk_done;

  task automatic begin_length(input parse_phase_t nxt);
    ph = nxt;
    len_acc = '0;
    len_seen = '0;
  endtask

  task automatic clear_parser();
    begin_length(P_DELTA);
    run_st = '0;
    cur_st = '0;
    held = '0;
    meta_type = '0;
    skip_left = '0;
    tempo_acc = '0;
    tick = '0;
    trk_done = 1'b0;
  endtask

  task automatic post_event(input mtep_kind_t k, input logic [7:0] st, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [TEMPO_W-1:0] us);
    mtep_result_t e;
    e.kind = k;
    e.abs_tick = tick;
    e.event_type = st[7:4];
    e.channel = st[3:0];
    e.first_data = d1;
    e.second_data = d2;
    e.tempo_us = us;
    events_due = {events_due, e};
  endtask

  task automatic abort_track();
    trk_done = 1'b1;
    ph = P_DONE;
    post_event(KIND_ERROR, 8'h00, 8'h00, 8'h00, '0);
  endtask

  task automatic length_step(input logic [7:0] b, output len_step_t r);
    len_acc = {len_acc[LEN_W-8:0], 7'(b & DATA_MASK)};
    len_seen = len_seen + 1'b1;
    if (!b[7]) r = LS_END;
    else if (len_seen >= MAX_LENGTH_BYTES) r = LS_OVER;
    else r = LS_MORE;
  endtask

  task automatic take_first_data(input logic [7:0] b);
    if (cur_st[7:4] == TYPE_PROGRAM || cur_st[7:4] == TYPE_PRESSURE) begin
      begin_length(P_DELTA);
      post_event(KIND_CHANNEL, cur_st, b, 8'h00, '0);
    end else begin
      held = b;
      ph = P_DATA2;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic nt);
    len_step_t r;
    if (nt) clear_parser();
    if (!trk_done) begin
      case (ph)
        P_STATUS: begin
          if (b < STATUS_MIN) begin
            if (run_st == 8'h00) begin
              abort_track();
            end else begin
              cur_st = run_st;
              take_first_data(b);
            end
          end else begin
            cur_st = b;
            if (b <= CHAN_MAX) begin
              run_st = b;
              ph = P_DATA1;
            end else begin
              run_st = 8'h00;
              if (b == META_STATUS) ph = P_META_TYPE;
              else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin_length(P_LEN);
              else begin_length(P_DELTA);
            end
          end
        end
        P_DATA1: take_first_data(b);
        P_DATA2: begin
          begin_length(P_DELTA);
          post_event(KIND_CHANNEL, cur_st, held, b, '0);
        end
        P_META_TYPE: begin
          meta_type = b;
          begin_length(P_LEN);
        end
        P_LEN: begin
          length_step(b, r);
          if (r == LS_OVER) begin
            abort_track();
          end else if (r == LS_END) begin
            if (cur_st == META_STATUS && meta_type == META_EOT) begin
              trk_done = 1'b1;
              ph = P_DONE;
              post_event(KIND_EOT, 8'h00, 8'h00, 8'h00, '0);
            end else if (cur_st == META_STATUS && meta_type == META_TEMPO &&
                         len_acc == TEMPO_LEN) begin
              skip_left = TEMPO_LEN;
              tempo_acc = '0;
              ph = P_TEMPO;
            end else if (len_acc == '0) begin
              begin_length(P_DELTA);
            end else begin
              skip_left = len_acc;
              ph = P_SKIP;
            end
          end
        end
        P_SKIP: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) begin_length(P_DELTA);
        end
        P_TEMPO: begin
          tempo_acc = {tempo_acc[TEMPO_W-9:0], b};
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) begin
            begin_length(P_DELTA);
            post_event(KIND_TEMPO, 8'h00, 8'h00, 8'h00, tempo_acc);
          end
        end
        P_DONE: begin
        end
        default: begin
          length_step(b, r);
          if (r == LS_OVER) begin
            abort_track();
          end else if (r == LS_END) begin
            tick = tick + TICK_W'(len_acc);
            ph = P_STATUS;
          end
        end
      endcase
    end
  endtask

  // stimulus builders

  task automatic add_byte(input logic [7:0] b, input logic nt);
    track_beat_t t;
    t.data = b;
    t.first = nt;
    pending = {pending, t};
  endtask

  task automatic add_payload(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) add_byte(8'($urandom), 1'b0);
  endtask

  task automatic add_len(input int unsigned v);
    if ($urandom_range(0, 7) == 0) add_byte(STATUS_MIN, 1'b0);
    add_byte(8'(v), 1'b0);
  endtask

  task automatic add_delta(input logic nt, input bit big);
    int unsigned n, r, i;
    logic [6:0] g;
    r = $urandom_range(0, 7);
    n = big ? 4 : (r < 4 ? 1 : (r < 6 ? 2 : (r < 7 ? 3 : 4)));
    for (i = 0; i < n; i++) begin
      g = (big && i == 0) ? 7'($urandom_range(7'h70, 7'h7F)) : 7'($urandom);
      add_byte({(i != n - 1), g}, (i == 0) ? nt : 1'b0);
    end
  endtask

  task automatic add_overlong();
    int unsigned i;
    for (i = 0; i < MAX_LENGTH_BYTES; i++) add_byte({1'b1, 7'($urandom)}, 1'b0);
  endtask

  function automatic logic [7:0] pick_data();
    pick_data = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] pick_system();
    int unsigned v;
    v = $urandom_range(0, 12);
    pick_system = (v < 6) ? 8'(8'hF1 + v) : 8'(8'hF8 + v - 6);
  endfunction

  task automatic add_track();
    int unsigned n_ev, e, k, len;
    bit big, rs_ok;
    logic [7:0] st, mt;
    big = ($urandom_range(0, 3) == 0);
    n_ev = big ? $urandom_range(20, 40) : $urandom_range(2, 25);
    rs_ok = 1'b0;
    st = 8'h00;
    for (e = 0; e < n_ev; e++) begin
      add_delta(e == 0, big);
      k = $urandom_range(0, 18);
      if (k < 12) begin
        if (rs_ok && $urandom_range(0, 2) == 0) begin
          add_byte(8'($urandom_range(0, 127)), 1'b0);
        end else begin
          st = 8'($urandom_range(8'h80, 8'hEF));
          add_byte(st, 1'b0);
          add_byte(pick_data(), 1'b0);
          rs_ok = 1'b1;
        end
        if (st[7:4] != TYPE_PROGRAM && st[7:4] != TYPE_PRESSURE) add_byte(pick_data(), 1'b0);
      end else begin
        rs_ok = 1'b0;
        if (k < 14) begin
          add_byte(META_STATUS, 1'b0);
          add_byte(META_TEMPO, 1'b0);
          len = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 6);
          add_len(len);
          add_payload(len);
        end else if (k < 16) begin
          mt = 8'($urandom);
          if (mt == META_EOT) mt = 8'h01;
          add_byte(META_STATUS, 1'b0);
          add_byte(mt, 1'b0);
          len = $urandom_range(0, 4);
          add_len(len);
          add_payload(len);
        end else if (k < 18) begin
          add_byte($urandom_range(0, 1) ? SYSEX_START : SYSEX_ESCAPE, 1'b0);
          len = $urandom_range(0, 6);
          add_len(len);
          add_payload(len);
        end else begin
          add_byte(pick_system(), 1'b0);
        end
      end
    end
    k = $urandom_range(0, 19);
    if (k < 15) begin
      add_delta(1'b0, big);
      add_byte(META_STATUS, 1'b0);
      add_byte(META_EOT, 1'b0);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      add_len(len);
      add_payload(len);
    end else if (k == 15) begin
      // data byte after running status was cleared
      add_delta(1'b0, 1'b0);
      add_byte(pick_system(), 1'b0);
      add_delta(1'b0, 1'b0);
      add_byte(8'($urandom_range(0, 127)), 1'b0);
    end else if (k == 16) begin
      add_overlong();
    end else if (k == 17) begin
      add_delta(1'b0, 1'b0);
      if ($urandom_range(0, 1)) begin
        add_byte(META_STATUS, 1'b0);
        add_byte(8'($urandom), 1'b0);
      end else begin
        add_byte(SYSEX_START, 1'b0);
      end
      add_overlong();
    end
    // bytes after the track is finished must be ignored
    if (k < 18 && $urandom_range(0, 1)) add_payload($urandom_range(1, 6));
  endtask

  task automatic add_noise();
    add_byte(8'($urandom), 1'b1);
    add_payload($urandom_range(5, 30));
  endtask

  task automatic check_event();
    mtep_result_t got, want;
    got.kind = event_if.kind;
    got.abs_tick = event_if.abs_tick;
    got.event_type = event_if.event_type;
    got.channel = event_if.channel;
    got.first_data = event_if.first_data;
    got.second_data = event_if.second_data;
    got.tempo_us = event_if.tempo_us;
    if (events_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected event beat: kind %0d tick %h type %h ch %h d %h %h tempo %h",
                 got.kind, got.abs_tick, got.event_type, got.channel, got.first_data,
                 got.second_data, got.tempo_us);
    end else begin
      want = events_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("event beat %0d expected kind %0d tick %h type %h ch %h d %h %h tempo %h",
                   beats_seen, want.kind, want.abs_tick, want.event_type, want.channel,
                   want.first_data, want.second_data, want.tempo_us);
          $display("event beat %0d actual   kind %0d tick %h type %h ch %h d %h %h tempo %h",
                   beats_seen, got.kind, got.abs_tick, got.event_type, got.channel,
                   got.first_data, got.second_data, got.tempo_us);
        end
      end
    end
  endtask

  // track byte driver
  always @(posedge clk) begin : track_source
    track_beat_t nxt;
    if (rst) begin
      track_if.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (track_if.valid && track_if.ready) begin
        take_byte(track_if.data_byte, track_if.new_track);
        bytes_taken++;
      end
      if (!track_if.valid || track_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          track_if.valid <= 1'b0;
        end else if (pending.size() == 0) begin
          track_if.valid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          track_if.valid <= 1'b1;
          track_if.data_byte <= nxt.data;
          track_if.new_track <= nxt.first;
          gap_left <= (((sent / 100) % 4) == 3) ? 0 : $urandom_range(0, 10);
          sent++;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk) begin : event_sink
    int unsigned n;
    if (rst) begin
      event_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (event_if.valid && event_if.ready) begin
      check_event();
      n = (((beats_seen / 40) % 4) == 1) ? 0 : $urandom_range(0, 10);
      beats_seen++;
      stall_left <= n;
      event_if.ready <= (n == 0) && !hold;
    end else if (hold || stall_left != 0) begin
      event_if.ready <= 1'b0;
      if (stall_left != 0) stall_left <= stall_left - 1;
    end else begin
      event_if.ready <= 1'b1;
    end
  end

  // long receiver hold-off so the parser backs up into the byte channel
  initial begin : long_hold
    hold = 1'b0;
    while (bytes_taken < 700) @(negedge clk);
    hold = 1'b1;
    repeat (300) @(negedge clk);
    hold = 1'b0;
  end

  initial begin : watchdog
    #8000000;
    $display("midi_track_event_parser: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;

    // note on at tick zero
    add_byte(8'h00, 1'b1);
    add_byte(8'h90, 1'b0);
    add_byte(8'h3C, 1'b0);
    add_byte(8'h7F, 1'b0);
    // largest delta, running status, status byte taken as data
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    // tempo
    add_byte(8'h00, 1'b0);
    add_byte(META_STATUS, 1'b0);
    add_byte(META_TEMPO, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'h07, 1'b0);
    add_byte(8'hA1, 1'b0);
    add_byte(8'h20, 1'b0);
    // end of track
    add_byte(8'h00, 1'b0);
    add_byte(META_STATUS, 1'b0);
    add_byte(META_EOT, 1'b0);
    add_byte(8'h00, 1'b0);
    // data with no running status
    add_byte(8'h00, 1'b1);
    add_byte(8'h40, 1'b0);
    // over-long delta
    add_byte(8'h80, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);

    while (pending.size() < ITEMS) begin
      if ($urandom_range(0, 14) == 0) add_noise();
      else add_track();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || track_if.valid || events_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (events_due.size() != 0)
      $display("%0d expected events never arrived", events_due.size());
    if (errors == 0 && events_due.size() == 0) $display("midi_track_event_parser: match");
    else $display("midi_track_event_parser: mismatch");
    $finish;
  end

endmodule
